// ----- sv/mrpc_pkg.sv -----
// ----------------------------------------------------------------------------
// mrpc_pkg
// Shared widths and types for the minimal rotation period block.
// ----------------------------------------------------------------------------
package mrpc_pkg;

    localparam int DIGIT_W = 32;
    localparam int PLEN_W  = 7;
    localparam int TDATA_W = 40;

    typedef struct packed {
        logic eq;
        logic gt;
    } cmp_res_t;

endpackage

// ----- sv/min_rotation_period_canon_top.sv -----
// ----------------------------------------------------------------------------
// min_rotation_period_canon_top
// Collects a digit sequence, finds its minimal rotation and shortest period,
// and streams that period out one digit per transfer.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                 | tlast       | tuser
//  s_      | in  | digit[31:0]                        | last_digit  | -
//  m_      | out | canon_digit[31:0], period_length   | last_of_run | overflowed
//
//  A non-final digit is taken with s_tready kept high. The final digit starts
//  a search in which each digit compare reads both operands through the
//  registered dual-read store, then each emitted digit is read from it too.
//  s_tready is low from the final digit until the last result is registered.
//  Reset clears the control state; the store needs no clearing.
//  A stalled m_ side holds the output register and the emit sequence.
// ----------------------------------------------------------------------------
module min_rotation_period_canon_top
    import mrpc_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [DIGIT_W-1:0] s_tdata,   // digit
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // canon_digit, period_length, zero pad
    output logic               m_tlast,
    output logic               m_tuser    // overflowed
);

    localparam int IW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    logic               we;
    logic [IW-1:0]      waddr;
    logic [IW-1:0]      addr_a;
    logic [IW-1:0]      addr_b;
    logic [DIGIT_W-1:0] rd_a;
    logic [DIGIT_W-1:0] rd_b;
    cmp_res_t           cmp;
    logic [DIGIT_W-1:0] out_digit;
    logic [PLEN_W-1:0]  out_plen;

    mrpc_store #(
        .MAX_LEN (MAX_LEN),
        .IW      (IW)
    ) u_store (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (s_tdata),
        .addr_a (addr_a),
        .addr_b (addr_b),
        .rd_a   (rd_a),
        .rd_b   (rd_b)
    );

    mrpc_cmp u_cmp (
        .a   (rd_a),
        .b   (rd_b),
        .res (cmp)
    );

    mrpc_seq #(
        .MAX_LEN (MAX_LEN),
        .IW      (IW),
        .CW      (CW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tlast   (s_tlast),
        .we        (we),
        .waddr     (waddr),
        .addr_a    (addr_a),
        .addr_b    (addr_b),
        .rd_a      (rd_a),
        .cmp       (cmp),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_digit (out_digit),
        .out_plen  (out_plen),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    assign m_tdata = {{(TDATA_W - DIGIT_W - PLEN_W){1'b0}}, out_plen, out_digit};

endmodule

// ----- sv/mrpc_cmp.sv -----
// ----------------------------------------------------------------------------
// mrpc_cmp
// Shared digit comparator: equality and unsigned greater-than.
// ----------------------------------------------------------------------------
module mrpc_cmp
    import mrpc_pkg::*;
(
    input  logic [DIGIT_W-1:0] a,
    input  logic [DIGIT_W-1:0] b,
    output cmp_res_t           res
);

    assign res.eq = (a == b);
    assign res.gt = (a > b);

endmodule

// ----- sv/mrpc_store.sv -----
// ----------------------------------------------------------------------------
// mrpc_store
// Sequence memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mrpc_store
    import mrpc_pkg::*;
#(
    parameter int MAX_LEN = 64,
    parameter int IW      = $clog2(MAX_LEN)
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [IW-1:0]      waddr,
    input  logic [DIGIT_W-1:0] wdata,
    input  logic [IW-1:0]      addr_a,
    input  logic [IW-1:0]      addr_b,
    output logic [DIGIT_W-1:0] rd_a,
    output logic [DIGIT_W-1:0] rd_b
);

    logic [DIGIT_W-1:0] mem [MAX_LEN];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a <= mem[addr_a];
        rd_b <= mem[addr_b];
    end

endmodule

// ----- sv/mrpc_seq.sv -----
// ----------------------------------------------------------------------------
// mrpc_seq
// Load, rotation search and emit sequencer with the output register.
// ----------------------------------------------------------------------------
module mrpc_seq
    import mrpc_pkg::*;
#(
    parameter int MAX_LEN = 64,
    parameter int IW      = $clog2(MAX_LEN),
    parameter int CW      = $clog2(MAX_LEN + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               s_tlast,
    output logic               we,
    output logic [IW-1:0]      waddr,
    output logic [IW-1:0]      addr_a,
    output logic [IW-1:0]      addr_b,
    input  logic [DIGIT_W-1:0] rd_a,
    input  cmp_res_t           cmp,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [DIGIT_W-1:0] out_digit,
    output logic [PLEN_W-1:0]  out_plen,
    output logic               m_tlast,
    output logic               m_tuser
);

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_ERD  = 3'd3;
    localparam logic [2:0] ST_ELD  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [IW-1:0]      i_reg, i_next;
    logic [CW-1:0]      j_reg, j_next;
    logic [IW-1:0]      k_reg, k_next;
    logic [IW-1:0]      pa_reg, pa_next;
    logic [IW-1:0]      pb_reg, pb_next;
    logic [IW-1:0]      start_reg, start_next;
    logic [CW-1:0]      period_reg, period_next;
    logic               vld_reg, vld_next;
    logic [DIGIT_W-1:0] dig_reg, dig_next;
    logic [PLEN_W-1:0]  plen_reg, plen_next;
    logic               last_reg, last_next;
    logic               user_reg, user_next;

    logic               acc;
    logic               full;
    logic [CW-1:0]      nm1;
    logic               out_free;
    logic               run_last;
    logic [IW-1:0]      i_cand;
    logic [CW-1:0]      j_inc;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p,
                                               input logic [CW-1:0] lim);
        logic [IW-1:0] r;
        if (CW'(p) == lim)
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign s_tready = (state_reg == ST_LOAD);
    assign acc      = s_tvalid && s_tready;
    assign full     = (count_reg == CW'(MAX_LEN));
    assign we       = acc && !full;
    assign waddr    = count_reg[IW-1:0];
    assign addr_a   = pa_reg;
    assign addr_b   = pb_reg;
    assign nm1      = count_reg - 1'b1;
    assign out_free = !vld_reg || m_tready;
    assign run_last = (CW'(k_reg) == period_reg - 1'b1);
    assign i_cand   = cmp.gt ? j_reg[IW-1:0] : i_reg;
    assign j_inc    = j_reg + 1'b1;

    assign m_tvalid  = vld_reg;
    assign out_digit = dig_reg;
    assign out_plen  = plen_reg;
    assign m_tlast   = last_reg;
    assign m_tuser   = user_reg;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        pa_next     = pa_reg;
        pb_next     = pb_reg;
        start_next  = start_reg;
        period_next = period_reg;
        vld_next    = vld_reg && !m_tready;
        dig_next    = dig_reg;
        plen_next   = plen_reg;
        last_next   = last_reg;
        user_next   = user_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (acc)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (s_tlast)
                    begin
                        k_next  = '0;
                        pa_next = '0;
                        i_next  = '0;
                        j_next  = CW'(1);
                        pb_next = IW'(1);
                        if (count_reg == '0)
                        begin
                            start_next  = '0;
                            period_next = CW'(1);
                            state_next  = ST_ERD;
                        end
                        else
                        begin
                            state_next = ST_RD;
                        end
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (cmp.eq)
                begin
                    if (CW'(k_reg) == nm1)
                    begin
                        start_next  = i_reg;
                        period_next = j_reg - CW'(i_reg);
                        pa_next     = i_reg;
                        k_next      = '0;
                        state_next  = ST_ERD;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        pa_next    = wrap_inc(pa_reg, nm1);
                        pb_next    = wrap_inc(pb_reg, nm1);
                        state_next = ST_RD;
                    end
                end
                else
                begin
                    k_next  = '0;
                    pa_next = i_cand;
                    if (j_inc == count_reg)
                    begin
                        start_next  = i_cand;
                        period_next = count_reg;
                        state_next  = ST_ERD;
                    end
                    else
                    begin
                        i_next     = i_cand;
                        j_next     = j_inc;
                        pb_next    = j_inc[IW-1:0];
                        state_next = ST_RD;
                    end
                end
            end
            ST_ERD:
            begin
                state_next = ST_ELD;
            end
            ST_ELD:
            begin
                if (out_free)
                begin
                    vld_next  = 1'b1;
                    dig_next  = rd_a;
                    plen_next = PLEN_W'(period_reg);
                    last_next = run_last;
                    user_next = ovf_reg;
                    if (run_last)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        pa_next    = wrap_inc(pa_reg, nm1);
                        k_next     = k_reg + 1'b1;
                        state_next = ST_ERD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            start_reg <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            start_reg <= start_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        period_reg <= period_next;
        dig_reg    <= dig_next;
        plen_reg   <= plen_next;
        last_reg   <= last_next;
        user_reg   <= user_next;
    end

endmodule

// ----- sv/mrpc_checker.sv -----
// ----------------------------------------------------------------------------
// mrpc_checker
// Port-level checks for the minimal rotation period block.
// ----------------------------------------------------------------------------
module mrpc_checker
    import mrpc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               s_tlast,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tlast,
    input logic               m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("output changed while stalled");

    a_mid_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast |=> s_tready)
        else $error("ready dropped after a non-final digit");

    a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("ready held after the final digit");

endmodule

bind min_rotation_period_canon_top mrpc_checker u_mrpc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
